// ----- rtl/exh_pkg.sv -----
// Shared types and constants for the exceedance histogram.
// Used by exh_cell, exh_limits, the top level and the testbench; no dependencies.
package exh_pkg;

    localparam int DATA_W   = 32;   // Q23.8 sample and limit width
    localparam int RANGE_W  = 23;
    localparam int FRAC_W   = 8;
    localparam int STEP_W   = RANGE_W + FRAC_W;
    localparam int BINCNT_W = 7;
    localparam int IDX_W    = 6;
    localparam int OUT_W    = 32;
    localparam int ACC_W    = STEP_W + IDX_W;
    localparam int SUM_W    = ACC_W + 2;
    localparam int DIVCNT_W = 5;

    localparam logic [BINCNT_W-1:0] BINS_MIN      = 7'd3;
    localparam logic [BINCNT_W-1:0] BIN_COUNT_RST = 7'd16;
    localparam logic [DATA_W-1:0]   LIMIT_LOWEST  = 32'h8000_0000;
    localparam logic [DATA_W-1:0]   LIMIT_HIGHEST = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        REG_MIN   = 2'd0,
        REG_MAX   = 2'd1,
        REG_RANGE = 2'd2,
        REG_BINS  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_UNLOAD
    } t_state;

    typedef enum logic [1:0] {
        LS_START,
        LS_DIV,
        LS_WALK,
        LS_IDLE
    } t_lstate;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] sample;
        logic              nodata;
        logic              last;
    } t_item;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_lim_wr;

endpackage

// ----- rtl/exh_cell.sv -----
// One histogram cell: holds one bin limit and its count, passes the sample on.
// Depends on exh_pkg.
module exh_cell #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [exh_pkg::IDX_W-1:0]     i_index,
    input  logic [exh_pkg::BINCNT_W-1:0]  i_bins,
    input  exh_pkg::t_lim_wr              i_lim,
    input  exh_pkg::t_item                i_item,
    output exh_pkg::t_item                o_item,
    input  logic                          i_shift,
    input  logic                          i_clear,
    input  logic [COUNT_WIDTH-1:0]        i_cnt_next,
    output logic [COUNT_WIDTH-1:0]        o_cnt
);

    exh_pkg::t_item                r_item;
    logic [exh_pkg::DATA_W-1:0]    r_limit;
    logic [COUNT_WIDTH-1:0]        r_cnt;
    logic                          w_en;
    logic                          w_hit;

    assign w_en  = ({1'b0, i_index} < i_bins);
    assign w_hit = i_item.valid && w_en &&
                   ((i_index == '0) ||
                    (!i_item.nodata && ($signed(i_item.sample) >= $signed(r_limit))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lim.we && (i_lim.idx == i_index)) begin
            r_limit <= i_lim.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_cnt <= '0;
        end else if (i_shift) begin
            r_cnt <= i_cnt_next;
        end else if (w_hit && (r_cnt != '1)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_item = r_item;
    assign o_cnt  = r_cnt;

endmodule

// ----- rtl/exh_limits.sv -----
// Configuration registers and bin limit builder (serial divider, then a walk over bins).
// Depends on exh_pkg.
module exh_limits #(
    parameter int MAX_BINS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic [exh_pkg::BINCNT_W-1:0]  o_bins,
    output exh_pkg::t_lim_wr              o_lim,
    output logic                          o_busy
);

    exh_pkg::t_lstate                 r_lstate, n_lstate;
    logic [exh_pkg::DATA_W-1:0]       r_min;
    logic [exh_pkg::DATA_W-1:0]       r_max;
    logic [exh_pkg::RANGE_W-1:0]      r_range;
    logic [exh_pkg::BINCNT_W-1:0]     r_bin_count;
    logic [exh_pkg::STEP_W-1:0]       r_dvd;
    logic [exh_pkg::BINCNT_W-1:0]     r_rem;
    logic [exh_pkg::DIVCNT_W-1:0]     r_dcnt;
    logic [exh_pkg::IDX_W-1:0]        r_k;
    logic [exh_pkg::ACC_W-1:0]        r_acc;
    logic [exh_pkg::BINCNT_W-1:0]     w_bins;
    logic [exh_pkg::BINCNT_W:0]       w_rem_sh;
    logic                             w_qbit;
    logic [exh_pkg::SUM_W-1:0]        w_sum;
    logic [exh_pkg::DATA_W-1:0]       w_mid;
    logic [exh_pkg::DATA_W-1:0]       w_lim;
    logic [exh_pkg::BINCNT_W-1:0]     w_k_ext;

    always_comb begin
        if (r_bin_count < exh_pkg::BINS_MIN) begin
            w_bins = exh_pkg::BINS_MIN;
        end else if (r_bin_count > exh_pkg::BINCNT_W'(MAX_BINS)) begin
            w_bins = exh_pkg::BINCNT_W'(MAX_BINS);
        end else begin
            w_bins = r_bin_count;
        end
    end
    assign o_bins = w_bins;

    // restoring divider step
    assign w_rem_sh = {r_rem, r_dvd[exh_pkg::STEP_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, w_bins});

    // min + k*step, saturated
    assign w_sum = exh_pkg::SUM_W'($signed(r_min)) + {2'b00, r_acc};
    always_comb begin
        if (!w_sum[exh_pkg::SUM_W-1] && (|w_sum[exh_pkg::SUM_W-2:exh_pkg::DATA_W-1])) begin
            w_mid = exh_pkg::LIMIT_HIGHEST;
        end else if (w_sum[exh_pkg::SUM_W-1] && !(&w_sum[exh_pkg::SUM_W-2:exh_pkg::DATA_W-1])) begin
            w_mid = exh_pkg::LIMIT_LOWEST;
        end else begin
            w_mid = w_sum[exh_pkg::DATA_W-1:0];
        end
    end

    assign w_k_ext = {1'b0, r_k};
    always_comb begin
        if (w_k_ext == (w_bins - 1'b1)) begin
            w_lim = r_max;
        end else if (r_k == exh_pkg::IDX_W'(1)) begin
            w_lim = r_min;
        end else if ((r_k == '0) || (w_k_ext >= w_bins)) begin
            w_lim = exh_pkg::LIMIT_LOWEST;
        end else begin
            w_lim = w_mid;
        end
    end

    always_comb begin
        n_lstate   = r_lstate;
        o_lim.we   = 1'b0;
        o_lim.idx  = r_k;
        o_lim.data = w_lim;
        case (r_lstate)
            exh_pkg::LS_START: n_lstate = exh_pkg::LS_DIV;
            exh_pkg::LS_DIV: begin
                if (r_dcnt == exh_pkg::DIVCNT_W'(exh_pkg::STEP_W - 1)) begin
                    n_lstate = exh_pkg::LS_WALK;
                end
            end
            exh_pkg::LS_WALK: begin
                o_lim.we = 1'b1;
                if (r_k == exh_pkg::IDX_W'(MAX_BINS - 1)) begin
                    n_lstate = exh_pkg::LS_IDLE;
                end
            end
            exh_pkg::LS_IDLE: n_lstate = exh_pkg::LS_IDLE;
            default:          n_lstate = exh_pkg::LS_START;
        endcase
        if (i_cfg_we) begin
            n_lstate = exh_pkg::LS_START;
        end
    end

    assign o_busy = (r_lstate != exh_pkg::LS_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lstate <= exh_pkg::LS_START;
        end else begin
            r_lstate <= n_lstate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '0;
            r_max       <= '0;
            r_range     <= '0;
            r_bin_count <= exh_pkg::BIN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (exh_pkg::t_cfg_idx'(i_cfg_index))
                exh_pkg::REG_MIN:   r_min       <= i_cfg_data;
                exh_pkg::REG_MAX:   r_max       <= i_cfg_data;
                exh_pkg::REG_RANGE: r_range     <= i_cfg_data[exh_pkg::RANGE_W-1:0];
                exh_pkg::REG_BINS:  r_bin_count <= i_cfg_data[exh_pkg::BINCNT_W-1:0];
                default:            r_min       <= r_min;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_lstate)
            exh_pkg::LS_START: begin
                r_dvd  <= {r_range, {exh_pkg::FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_dcnt <= '0;
                r_k    <= '0;
                r_acc  <= '0;
            end
            exh_pkg::LS_DIV: begin
                r_dvd  <= {r_dvd[exh_pkg::STEP_W-2:0], w_qbit};
                r_rem  <= w_qbit ? exh_pkg::BINCNT_W'(w_rem_sh - {1'b0, w_bins})
                                 : w_rem_sh[exh_pkg::BINCNT_W-1:0];
                r_dcnt <= r_dcnt + 1'b1;
            end
            exh_pkg::LS_WALK: begin
                r_k   <= r_k + 1'b1;
                r_acc <= r_acc + exh_pkg::ACC_W'(r_dvd);
            end
            default: r_k <= r_k;
        endcase
    end

endmodule

// ----- rtl/exceedance_histogram.sv -----
// Top level of the exceedance histogram: stream ports, control and the row of cells.
// Depends on exh_pkg, exh_cell, exh_limits.
//
// Usage: samples arrive on the s_axis channel (tdata = sample, tuser = no-data flag,
// tlast = final sample of a data set). Each of MAX_BINS cells holds one bin limit and
// count; a sample moves one cell per cycle down the row, so samples are taken one
// per cycle while a data set streams in.
// After a request with tlast, input stalls while that sample walks the row,
// then the n bin counts leave on m_axis, one per cycle while m_axis is ready, in bin
// order (tdata = bin index, count; tlast on the final bin). Counts are cleared after
// the final bin and input reopens the cycle after.
// A stall on m_axis holds the current bin; nothing is lost.
// Configuration requests are taken at any time; each one rebuilds the bin limits:
// a set-up state, serial division for the step, then a walk that loads the cells.
// Input is held off during the rebuild. Reset clears all counts and runs the same
// rebuild with the reset register values.
module exceedance_histogram #(
    parameter int MAX_BINS    = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] sample
    input  logic        i_s_axis_tuser,   // [0] is_nodata
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [5:0] bin_index, [37:6] exceed_count, [39:38] zero
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    exh_pkg::t_state                 r_state, n_state;
    logic [exh_pkg::IDX_W-1:0]       r_out_idx;
    logic [exh_pkg::BINCNT_W-1:0]    w_bins;
    exh_pkg::t_lim_wr                w_lim;
    logic                            w_busy;
    exh_pkg::t_item                  w_item [0:MAX_BINS];
    logic [COUNT_WIDTH-1:0]          w_cnt  [0:MAX_BINS];
    logic [exh_pkg::OUT_W-1:0]       w_out_cnt;
    logic                            w_in_req;
    logic                            w_out_req;
    logic                            w_out_last;
    logic                            w_shift;
    logic                            w_clear;

    assign o_cfg_ready = 1'b1;

    exh_limits #(
        .MAX_BINS (MAX_BINS)
    ) u_limits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bins      (w_bins),
        .o_lim       (w_lim),
        .o_busy      (w_busy)
    );

    assign o_s_axis_tready = (r_state == exh_pkg::ST_RUN) && !w_busy;
    assign w_in_req        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_item[0].valid  = w_in_req;
    assign w_item[0].sample = i_s_axis_tdata;
    assign w_item[0].nodata = i_s_axis_tuser;
    assign w_item[0].last   = i_s_axis_tlast;
    assign w_cnt[MAX_BINS]  = '0;

    for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
        exh_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (exh_pkg::IDX_W'(g)),
            .i_bins     (w_bins),
            .i_lim      (w_lim),
            .i_item     (w_item[g]),
            .o_item     (w_item[g+1]),
            .i_shift    (w_shift),
            .i_clear    (w_clear),
            .i_cnt_next (w_cnt[g+1]),
            .o_cnt      (w_cnt[g])
        );
    end

    if (COUNT_WIDTH > exh_pkg::OUT_W) begin : g_sat
        assign w_out_cnt = (|w_cnt[0][COUNT_WIDTH-1:exh_pkg::OUT_W]) ? '1
                                                                      : w_cnt[0][exh_pkg::OUT_W-1:0];
    end else begin : g_ext
        assign w_out_cnt = exh_pkg::OUT_W'(w_cnt[0]);
    end

    assign w_out_last      = ({1'b0, r_out_idx} == (w_bins - 1'b1));
    assign o_m_axis_tdata  = {2'b00, w_out_cnt, r_out_idx};
    assign o_m_axis_tlast  = w_out_last;
    assign w_out_req       = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        n_state         = r_state;
        o_m_axis_tvalid = 1'b0;
        w_shift         = 1'b0;
        w_clear         = 1'b0;
        case (r_state)
            exh_pkg::ST_RUN: begin
                if (w_in_req && i_s_axis_tlast) begin
                    n_state = exh_pkg::ST_DRAIN;
                end
            end
            exh_pkg::ST_DRAIN: begin
                if (w_item[MAX_BINS].valid && w_item[MAX_BINS].last) begin
                    n_state = exh_pkg::ST_UNLOAD;
                end
            end
            exh_pkg::ST_UNLOAD: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    w_shift = 1'b1;
                    if (w_out_last) begin
                        w_clear = 1'b1;
                        n_state = exh_pkg::ST_RUN;
                    end
                end
            end
            default: n_state = exh_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= exh_pkg::ST_RUN;
            r_out_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_req) begin
                r_out_idx <= w_out_last ? '0 : r_out_idx + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/exh_checker.sv -----
// Port-level checks for the exceedance histogram, bound to the top level.
// Depends on exceedance_histogram ports only.
module exh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output request changed while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input open while bins unload");

    a_first_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (o_m_axis_tdata[5:0] == 6'd0))
        else $error("unload does not start at bin zero");

    a_next_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid &&
             (o_m_axis_tdata[5:0] == 6'($past(o_m_axis_tdata[5:0]) + 6'd1))))
        else $error("bin sequence broken");

    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("output continues after final bin");

endmodule

bind exceedance_histogram exh_checker u_exh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- verif/exceedance_histogram_tb.sv -----
// Self-checking testbench for exceedance_histogram: directed edge cases, then random data sets.
// Holds its own model of the bin limits and counts. Depends on exh_pkg and the block's RTL.
module exceedance_histogram_tb;

    localparam int MAX_BINS     = 16;
    localparam int DRAIN_CYCLES = MAX_BINS + 16;
    localparam int RAND_ITEMS   = 234;
    localparam int CALM_TAIL    = 40;
    localparam longint S32_MAX  = longint'(32'sh7FFF_FFFF);
    localparam longint S32_MIN  = longint'(32'sh8000_0000);

    typedef struct {
        logic [exh_pkg::IDX_W-1:0] bin;
        logic [exh_pkg::OUT_W-1:0] tally;
        logic                      final_bin;
    } t_bin_report;

    logic                       i_clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_valid = 1'b0;
    logic [exh_pkg::DATA_W-1:0] s_sample = '0;
    logic                       s_nodata = 1'b0;
    logic                       s_last = 1'b0;
    logic                       m_ready = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [1:0]                 cfg_index = '0;
    logic [exh_pkg::DATA_W-1:0] cfg_data = '0;

    wire               s_ready;
    wire               m_valid;
    wire [39:0]        m_data;
    wire               m_last;
    wire               cfg_ready;

    // histogram model
    logic signed [exh_pkg::DATA_W-1:0] min_reg, max_reg;
    logic [exh_pkg::RANGE_W-1:0]       range_reg;
    logic [exh_pkg::BINCNT_W-1:0]      bins_reg;
    logic signed [exh_pkg::DATA_W-1:0] bin_floor [MAX_BINS];
    logic [exh_pkg::OUT_W-1:0]         bin_tally [MAX_BINS];
    t_bin_report                       reports_due[$];

    int errors = 0;
    int samples_sent = 0;
    int sets_closed = 0;
    int reports_checked = 0;
    int reg_writes = 0;
    int idle_pct = 0;
    int rx_hold = 0;

    always #5 i_clk = ~i_clk;

    exceedance_histogram #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_WIDTH(32)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_sample),
        .i_s_axis_tuser (s_nodata),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    function automatic logic [exh_pkg::DATA_W-1:0] q8(int units);
        return units <<< exh_pkg::FRAC_W;
    endfunction

    function automatic int bins_in_use();
        int n;
        n = int'(bins_reg);
        if (n < 3) n = 3;
        if (n > MAX_BINS) n = MAX_BINS;
        return n;
    endfunction

    function automatic void rebuild_floors();
        int     n;
        longint step;
        longint v;
        n = bins_in_use();
        step = longint'({range_reg, 8'h00}) / longint'(n);
        for (int k = 0; k < MAX_BINS; k++) bin_floor[k] = exh_pkg::LIMIT_LOWEST;
        bin_floor[1] = min_reg;
        for (int k = 2; k + 1 < n; k++) begin
            v = longint'(min_reg) + longint'(k) * step;
            if (v > S32_MAX) bin_floor[k] = exh_pkg::LIMIT_HIGHEST;
            else if (v < S32_MIN) bin_floor[k] = exh_pkg::LIMIT_LOWEST;
            else bin_floor[k] = v[31:0];
        end
        bin_floor[n-1] = max_reg;
    endfunction

    function automatic void reset_histogram();
        min_reg = '0;
        max_reg = '0;
        range_reg = '0;
        bins_reg = exh_pkg::BIN_COUNT_RST;
        for (int k = 0; k < MAX_BINS; k++) bin_tally[k] = '0;
        rebuild_floors();
    endfunction

    function automatic void apply_reg(exh_pkg::t_cfg_idx idx, logic [exh_pkg::DATA_W-1:0] val);
        case (idx)
            exh_pkg::REG_MIN:   min_reg = val;
            exh_pkg::REG_MAX:   max_reg = val;
            exh_pkg::REG_RANGE: range_reg = val[exh_pkg::RANGE_W-1:0];
            exh_pkg::REG_BINS:  bins_reg = val[exh_pkg::BINCNT_W-1:0];
            default:            min_reg = min_reg;
        endcase
        rebuild_floors();
    endfunction

    function automatic void tally_sample(logic signed [exh_pkg::DATA_W-1:0] s, logic nd,
                                         logic last);
        int          n;
        t_bin_report r;
        n = bins_in_use();
        if (bin_tally[0] != '1) bin_tally[0]++;
        if (!nd) begin
            for (int k = 1; k < n; k++)
                if (s >= bin_floor[k] && bin_tally[k] != '1) bin_tally[k]++;
        end
        if (last) begin
            for (int k = 0; k < n; k++) begin
                r.bin = exh_pkg::IDX_W'(k);
                r.tally = bin_tally[k];
                r.final_bin = (k == n - 1);
                reports_due.push_back(r);
            end
            for (int k = 0; k < MAX_BINS; k++) bin_tally[k] = '0;
            sets_closed++;
        end
    endfunction

    // output side: random back-pressure bursts
    always @(posedge i_clk) begin : rx_pace
        logic ready_nxt;
        if (rx_hold > 0) begin
            rx_hold--;
            ready_nxt = 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            rx_hold = $urandom_range(0, 13);
            ready_nxt = 1'b0;
        end else begin
            ready_nxt = 1'b1;
        end
        m_ready <= ready_nxt;
    end

    always @(posedge i_clk) begin : report_check
        t_bin_report r;
        if (rst_n && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected report: expected none, actual bin %0d count %0d",
                         $time, m_data[5:0], m_data[37:6]);
            end else begin
                r = reports_due.pop_front();
                reports_checked++;
                if (m_data[5:0] !== r.bin) begin
                    errors++;
                    $display("%0t: bin index expected %0d actual %0d",
                             $time, r.bin, m_data[5:0]);
                end
                if (m_data[37:6] !== r.tally) begin
                    errors++;
                    $display("%0t: bin %0d count expected %0d actual %0d",
                             $time, r.bin, r.tally, m_data[37:6]);
                end
                if (m_last !== r.final_bin) begin
                    errors++;
                    $display("%0t: bin %0d tlast expected %0b actual %0b",
                             $time, r.bin, r.final_bin, m_last);
                end
            end
        end
    end

    // valid stays high on return; the next request or settle() moves it
    task automatic send_item(logic [exh_pkg::DATA_W-1:0] s, logic nd, logic last);
        cfg_valid <= 1'b0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_sample <= s;
        s_nodata <= nd;
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
        tally_sample(s, nd, last);
        samples_sent++;
    endtask

    task automatic reg_write(exh_pkg::t_cfg_idx idx, logic [exh_pkg::DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(logic [exh_pkg::DATA_W-1:0] mn, logic [exh_pkg::DATA_W-1:0] mx,
                             logic [exh_pkg::DATA_W-1:0] rng, logic [exh_pkg::DATA_W-1:0] nb);
        reg_write(exh_pkg::REG_MIN, mn);
        reg_write(exh_pkg::REG_MAX, mx);
        reg_write(exh_pkg::REG_RANGE, rng);
        reg_write(exh_pkg::REG_BINS, nb);
    endtask

    function automatic logic [exh_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return q8($urandom_range(0, 2000) - 1000);
            2: return $urandom_range(0, 1) ? exh_pkg::LIMIT_HIGHEST : exh_pkg::LIMIT_LOWEST;
            default: return $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    function automatic logic [exh_pkg::DATA_W-1:0] pick_bins();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 2);
            1: return $urandom_range(17, 127);
            2: return $urandom_range(0, 1) ? 3 : MAX_BINS;
            default: return $urandom_range(3, MAX_BINS);
        endcase
    endfunction

    function automatic logic [exh_pkg::DATA_W-1:0] pick_sample();
        int k;
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1) ? exh_pkg::LIMIT_HIGHEST : exh_pkg::LIMIT_LOWEST;
            default: begin
                k = $urandom_range(0, bins_in_use() - 1);
                return bin_floor[k] + 32'($urandom_range(0, 4)) - 32'd2;
            end
        endcase
    endfunction

    task automatic random_config();
        logic [exh_pkg::DATA_W-1:0] mn;
        mn = pick_value();
        if ($urandom_range(0, 1)) reg_write(exh_pkg::REG_MIN, mn);
        if ($urandom_range(0, 1))
            reg_write(exh_pkg::REG_MAX, $urandom_range(0, 2) == 0 ? pick_value()
                                                    : mn + q8($urandom_range(0, 4000)));
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0: reg_write(exh_pkg::REG_RANGE, 0);
                1: reg_write(exh_pkg::REG_RANGE, 32'h007F_FFFF);
                2: reg_write(exh_pkg::REG_RANGE, $urandom_range(1, 4000));
                default: reg_write(exh_pkg::REG_RANGE, $urandom & 32'h007F_FFFF);
            endcase
        end
        if ($urandom_range(0, 1)) reg_write(exh_pkg::REG_BINS, pick_bins());
    endtask

    // reset limits: bin 0 lowest, all others zero
    task automatic test_reset_state();
        idle_pct = 30;
        send_item(32'd0, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(exh_pkg::LIMIT_HIGHEST, 1'b0, 1'b0);
        send_item(exh_pkg::LIMIT_LOWEST, 1'b0, 1'b0);
        send_item(exh_pkg::LIMIT_HIGHEST, 1'b1, 1'b1);
    endtask

    // samples on the limits and just below them
    task automatic test_limit_edges();
        settle();
        write_all(q8(-100), q8(100), 200, 10);
        send_item(q8(-100), 1'b0, 1'b0);
        send_item(q8(-100) - 1, 1'b0, 1'b0);
        send_item(q8(100), 1'b0, 1'b0);
        send_item(q8(100) - 1, 1'b0, 1'b0);
        send_item(q8(-60), 1'b0, 1'b0);
        send_item(exh_pkg::LIMIT_HIGHEST, 1'b1, 1'b1);
    endtask

    // bin count below, at the bottom of and above the usable span
    task automatic test_bin_clamp();
        logic [exh_pkg::DATA_W-1:0] nb [5] = '{0, 2, 127, 17, 3};
        foreach (nb[i]) begin
            settle();
            reg_write(exh_pkg::REG_BINS, nb[i]);
            send_item(q8(150), 1'b0, 1'b1);
        end
    endtask

    // middle limits saturating, and max below min
    task automatic test_limit_overflow();
        settle();
        write_all(32'h7FFF_0000, exh_pkg::LIMIT_LOWEST, 32'h007F_FFFF, MAX_BINS);
        send_item(exh_pkg::LIMIT_HIGHEST, 1'b0, 1'b0);
        send_item(32'h7FFF_0000, 1'b0, 1'b0);
        send_item(exh_pkg::LIMIT_LOWEST, 1'b0, 1'b1);
        settle();
        write_all(exh_pkg::LIMIT_LOWEST, exh_pkg::LIMIT_HIGHEST, 32'h007F_FFFF, 4);
        send_item(exh_pkg::LIMIT_LOWEST, 1'b0, 1'b0);
        send_item(32'h4000_0000, 1'b0, 1'b1);
    endtask

    // fewer bins mid set: dropped bins must still be cleared
    task automatic test_shrink_mid_set();
        settle();
        write_all(0, q8(1000), 1000, MAX_BINS);
        send_item(q8(1000), 1'b0, 1'b0);
        send_item(q8(900), 1'b0, 1'b0);
        settle();
        reg_write(exh_pkg::REG_BINS, 5);
        send_item(q8(500), 1'b0, 1'b0);
        send_item(q8(1000), 1'b0, 1'b1);
        settle();
        reg_write(exh_pkg::REG_BINS, MAX_BINS);
        send_item(q8(1000), 1'b0, 1'b1);
    endtask

    task automatic test_random_sets();
        int done_items;
        int len;
        int split;
        done_items = 0;
        while (done_items < RAND_ITEMS) begin
            if (done_items >= RAND_ITEMS - CALM_TAIL) idle_pct = 0;
            else begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 35;
                endcase
            end
            if ($urandom_range(0, 1)) begin
                settle();
                random_config();
            end
            len = $urandom_range(1, 20);
            split = ($urandom_range(0, 5) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
            for (int i = 0; i < len; i++) begin
                if (split != 0 && i == split) begin
                    settle();
                    reg_write(exh_pkg::REG_BINS, pick_bins());
                end
                send_item(pick_sample(), $urandom_range(0, 7) == 0, i == len - 1);
                done_items++;
            end
        end
    endtask

    initial begin
        reset_histogram();
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_limit_edges();
        test_bin_clamp();
        test_limit_overflow();
        test_shrink_mid_set();
        test_random_sets();
        settle();
        $display("Covered %0d samples in %0d data sets with %0d register writes;",
                 samples_sent, sets_closed, reg_writes);
        $display("%0d bin counts compared, %0d errors.", reports_checked, errors);
        if (errors == 0) begin
            $display("exceedance_histogram regression: pass");
        end else begin
            $display("exceedance_histogram regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d bin counts outstanding.", reports_due.size());
        $display("exceedance_histogram regression: fail");
        $finish;
    end

endmodule
